// ----- hdl/bpo_pkg.sv -----
// ----------------------------------------------------------------------------
// bpo_pkg
// Shared types and constants for the beat phase offset block.
// ----------------------------------------------------------------------------
package bpo_pkg;

    localparam int RATE_W      = 18;
    localparam int POS_FIELD_W = 32;
    localparam int TEMPO_W     = 16;
    localparam int SUM_W       = TEMPO_W + 1;
    localparam int NUM_BASE_W  = 31;    // 6000 * sample_rate
    localparam int DEN_W       = 32;    // 12000 * sample_rate
    localparam int PH_W        = 33;    // signed deck phase in frames
    localparam int OFF_W       = 33;
    localparam int MAG_W       = 32;
    localparam int PROD_W      = MAG_W + SUM_W;
    localparam int Q_FRAC      = 15;
    localparam int BEATS_W     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RATE_W-1:0] RATE_RESET        = 18'd44100;
    localparam logic [12:0]       CENTI_MINUTE      = 13'd6000;
    localparam logic [13:0]       TWO_CENTI_MINUTE  = 14'd12000;
    localparam logic signed [PH_W:0] OFF_LIMIT      = 34'sd4294967295;
    localparam logic signed [BEATS_W:0] HALF_BEAT   = 17'sd16384;
    localparam logic signed [BEATS_W:0] FULL_BEAT   = 17'sd32768;

    typedef struct packed {
        logic [POS_FIELD_W-1:0] position_a;
        logic [POS_FIELD_W-1:0] position_b;
        logic [TEMPO_W-1:0]     tempo_a_centi;
        logic [TEMPO_W-1:0]     tempo_b_centi;
        logic                   invalid;
    } t_item;

endpackage

// ----- hdl/bpo_in_if.sv -----
// ----------------------------------------------------------------------------
// bpo_in_if
// Input channel: two deck positions and two tempos.
// ----------------------------------------------------------------------------
interface bpo_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] position_a;
    logic [31:0] position_b;
    logic [15:0] tempo_a_centi;
    logic [15:0] tempo_b_centi;

    modport source (output valid, output position_a, output position_b,
                    output tempo_a_centi, output tempo_b_centi, input ready);
    modport sink   (input valid, input position_a, input position_b,
                    input tempo_a_centi, input tempo_b_centi, output ready);
endinterface

// ----- hdl/bpo_out_if.sv -----
// ----------------------------------------------------------------------------
// bpo_out_if
// Output channel: phase offset in frames and in beats, tempo flag.
// ----------------------------------------------------------------------------
interface bpo_out_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] offset_samples;
    logic signed [15:0] offset_beats_q15;
    logic               tempo_invalid;

    modport source (output valid, output offset_samples, output offset_beats_q15,
                    output tempo_invalid, input ready);
    modport sink   (input valid, input offset_samples, input offset_beats_q15,
                    input tempo_invalid, output ready);
endinterface

// ----- hdl/bpo_rem_pipe.sv -----
// ----------------------------------------------------------------------------
// bpo_rem_pipe
// Pipelined restoring divider, one dividend bit per stage. Gives remainder,
// low quotient bits and carries the divisor and a sideband along.
// ----------------------------------------------------------------------------
module bpo_rem_pipe #(
    parameter int DW,
    parameter int VW,
    parameter int QB,
    parameter int SW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dvd,
    input  logic [VW-1:0] i_dvs,
    input  logic [SW-1:0] i_sb,
    output logic          o_valid,
    output logic [VW-1:0] o_rem,
    output logic [QB-1:0] o_quo,
    output logic [VW-1:0] o_dvs,
    output logic [SW-1:0] o_sb
);

    logic          r_valid [DW];
    logic [VW-1:0] r_rem   [DW];
    logic [DW-1:0] r_dvd   [DW];
    logic [VW-1:0] r_dvs   [DW];
    logic [QB-1:0] r_quo   [DW];
    logic [SW-1:0] r_sb    [DW];

    for (genvar s = 0; s < DW; s++) begin : g_stage
        logic          src_valid;
        logic [VW-1:0] src_rem;
        logic [DW-1:0] src_dvd;
        logic [VW-1:0] src_dvs;
        logic [QB-1:0] src_quo;
        logic [SW-1:0] src_sb;
        logic [VW:0]   n_ext;
        logic [VW:0]   n_diff;
        logic          n_ge;

        if (s == 0) begin : g_first
            assign src_valid = i_valid;
            assign src_rem   = '0;
            assign src_dvd   = i_dvd;
            assign src_dvs   = i_dvs;
            assign src_quo   = '0;
            assign src_sb    = i_sb;
        end else begin : g_next
            assign src_valid = r_valid[s-1];
            assign src_rem   = r_rem[s-1];
            assign src_dvd   = r_dvd[s-1];
            assign src_dvs   = r_dvs[s-1];
            assign src_quo   = r_quo[s-1];
            assign src_sb    = r_sb[s-1];
        end

        assign n_ext  = {src_rem, src_dvd[DW-1]};
        assign n_ge   = n_ext >= {1'b0, src_dvs};
        assign n_diff = n_ext - {1'b0, src_dvs};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_ge ? n_diff[VW-1:0] : n_ext[VW-1:0];
                r_dvd[s] <= src_dvd << 1;
                r_dvs[s] <= src_dvs;
                r_quo[s] <= QB'({src_quo, n_ge});
                r_sb[s]  <= src_sb;
            end
        end
    end

    assign o_valid = r_valid[DW-1];
    assign o_rem   = r_rem[DW-1];
    assign o_quo   = r_quo[DW-1];
    assign o_dvs   = r_dvs[DW-1];
    assign o_sb    = r_sb[DW-1];

endmodule

// ----- hdl/bpo_front.sv -----
// ----------------------------------------------------------------------------
// bpo_front
// Holds the sample rate register, accepts queries, flags bad tempos or a zero
// rate and queues them for the compute pipeline.
// ----------------------------------------------------------------------------
module bpo_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wen,
    input  logic [bpo_pkg::RATE_W-1:0] i_cfg_wdata,
    bpo_in_if.sink                     i_in,
    output bpo_pkg::t_item             o_item,
    output logic                       o_item_valid,
    input  logic                       i_item_ready,
    output logic [bpo_pkg::RATE_W-1:0] o_sample_rate
);

    logic [bpo_pkg::RATE_W-1:0] r_sample_rate;
    bpo_pkg::t_item             r_queue [bpo_pkg::QUEUE_DEPTH];
    logic [bpo_pkg::QPTR_W-1:0] r_wptr;
    logic [bpo_pkg::QPTR_W-1:0] r_rptr;
    logic [bpo_pkg::QCNT_W-1:0] r_count;
    bpo_pkg::t_item             n_item;
    logic                       push;
    logic                       pop;

    assign i_in.ready    = r_count != bpo_pkg::QCNT_W'(bpo_pkg::QUEUE_DEPTH);
    assign push          = i_in.valid && i_in.ready;
    assign o_item_valid  = r_count != '0;
    assign pop           = o_item_valid && i_item_ready;
    assign o_item        = r_queue[r_rptr];
    assign o_sample_rate = r_sample_rate;

    always_comb begin
        n_item.position_a    = i_in.position_a;
        n_item.position_b    = i_in.position_b;
        n_item.tempo_a_centi = i_in.tempo_a_centi;
        n_item.tempo_b_centi = i_in.tempo_b_centi;
        // zero tempo or zero rate would divide by zero
        n_item.invalid = (i_in.tempo_a_centi == '0) || (i_in.tempo_b_centi == '0)
                         || (r_sample_rate == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= bpo_pkg::RATE_RESET;
            r_wptr        <= '0;
            r_rptr        <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_sample_rate <= i_cfg_wdata;
            end
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wptr] <= n_item;
        end
    end

endmodule

// ----- hdl/bpo_back.sv -----
// ----------------------------------------------------------------------------
// bpo_back
// Compute pipeline: beat length per deck, deck phases, frame offset,
// offset in beats, output register.
// ----------------------------------------------------------------------------
module bpo_back #(
    parameter int POSITION_BITS,
    parameter int BEAT_FRACTION_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bpo_pkg::RATE_W-1:0] i_sample_rate,
    input  bpo_pkg::t_item             i_item,
    input  logic                       i_item_valid,
    output logic                       o_item_ready,
    bpo_out_if.source                  o_out
);

    localparam int F   = BEAT_FRACTION_BITS;
    localparam int PW  = POSITION_BITS;
    localparam int NW  = bpo_pkg::NUM_BASE_W + F;
    localparam int DPW = PW + F;
    localparam int FDW = bpo_pkg::PROD_W + bpo_pkg::Q_FRAC;
    localparam int OW  = bpo_pkg::OFF_W;

    // phase of a position from (pos * 2^F) mod spb
    function automatic logic signed [bpo_pkg::PH_W-1:0] deck_phase(
        input logic [NW-1:0] rem,
        input logic [NW-1:0] spb
    );
        logic [NW:0]   up;
        logic [NW-1:0] dn;
        up = {1'b0, rem} + (NW+1)'((1 << F) - 1);
        dn = spb - rem;
        if ({rem, 1'b0} >= {1'b0, spb}) begin
            deck_phase = -$signed({2'b00, dn[NW-1:F]});
        end else begin
            deck_phase = $signed({1'b0, up[NW:F]});
        end
    endfunction

    logic                en;
    logic [NW-1:0]       r_num;
    logic [bpo_pkg::DEN_W-1:0] r_den;
    logic [PW-1:0]       pa0;
    logic [PW-1:0]       pb0;
    logic [bpo_pkg::SUM_W-1:0] sum0;

    logic                v1;
    logic [NW-1:0]       spb_a1;
    logic [NW-1:0]       spb_b1;
    logic [PW+bpo_pkg::SUM_W:0] sb_a1;
    logic [PW-1:0]       pb1;
    logic                v1_b;

    logic                v2;
    logic [NW-1:0]       rem_a2;
    logic [NW-1:0]       rem_b2;
    logic [NW-1:0]       spb_a2;
    logic [NW-1:0]       spb_b2;
    logic [bpo_pkg::SUM_W-1:0] sum2;
    logic                inv2;

    logic                r_v3;
    logic signed [bpo_pkg::PH_W-1:0] r_ph_a3;
    logic signed [bpo_pkg::PH_W-1:0] r_ph_b3;
    logic [bpo_pkg::SUM_W-1:0] r_sum3;
    logic                r_inv3;

    logic signed [bpo_pkg::PH_W:0] n_diff4;
    logic signed [OW-1:0]  n_off4;
    logic                r_v4;
    logic signed [OW-1:0]  r_off4;
    logic [bpo_pkg::MAG_W-1:0] r_mag4;
    logic [bpo_pkg::SUM_W-1:0] r_sum4;
    logic                r_inv4;

    logic                r_v5;
    logic [bpo_pkg::PROD_W-1:0] r_prod5;
    logic signed [OW-1:0]  r_off5;
    logic                r_inv5;

    logic                v6;
    logic [bpo_pkg::DEN_W-1:0] rem6;
    logic [bpo_pkg::DEN_W-1:0] den6;
    logic [bpo_pkg::Q_FRAC-1:0] quo6;
    logic [OW:0]         sb6;

    logic [bpo_pkg::BEATS_W-1:0]   n_q;
    logic signed [bpo_pkg::BEATS_W:0] n_b;
    logic signed [bpo_pkg::BEATS_W:0] n_wrap;

    logic                r_out_valid;
    logic signed [OW-1:0]  r_out_off;
    logic signed [bpo_pkg::BEATS_W-1:0] r_out_beats;
    logic                r_out_inv;

    // whole pipeline advances together; stall only when the output is held
    assign en           = !r_out_valid || o_out.ready;
    assign o_item_ready = en;

    always_ff @(posedge i_clk) begin
        r_num <= {bpo_pkg::NUM_BASE_W'(i_sample_rate * bpo_pkg::CENTI_MINUTE), F'(0)};
        r_den <= bpo_pkg::DEN_W'(i_sample_rate * bpo_pkg::TWO_CENTI_MINUTE);
    end

    assign pa0  = PW'(i_item.position_a);
    assign pb0  = PW'(i_item.position_b);
    assign sum0 = bpo_pkg::SUM_W'(i_item.tempo_a_centi)
                + bpo_pkg::SUM_W'(i_item.tempo_b_centi);

    // samples per beat, F fraction bits
    bpo_rem_pipe #(.DW(NW), .VW(bpo_pkg::TEMPO_W), .QB(NW), .SW(PW + bpo_pkg::SUM_W + 1))
    u_spb_a (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_item_valid),
        .i_dvd(r_num), .i_dvs(i_item.tempo_a_centi),
        .i_sb({pa0, sum0, i_item.invalid}),
        .o_valid(v1), .o_rem(), .o_quo(spb_a1), .o_dvs(), .o_sb(sb_a1)
    );

    bpo_rem_pipe #(.DW(NW), .VW(bpo_pkg::TEMPO_W), .QB(NW), .SW(PW)) u_spb_b (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_item_valid),
        .i_dvd(r_num), .i_dvs(i_item.tempo_b_centi), .i_sb(pb0),
        .o_valid(v1_b), .o_rem(), .o_quo(spb_b1), .o_dvs(), .o_sb(pb1)
    );

    // (pos * 2^F) mod spb for each deck
    bpo_rem_pipe #(.DW(DPW), .VW(NW), .QB(1), .SW(bpo_pkg::SUM_W)) u_phase_a (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v1),
        .i_dvd({sb_a1[PW+bpo_pkg::SUM_W:bpo_pkg::SUM_W+1], F'(0)}), .i_dvs(spb_a1),
        .i_sb(sb_a1[bpo_pkg::SUM_W:1]),
        .o_valid(v2), .o_rem(rem_a2), .o_quo(), .o_dvs(spb_a2), .o_sb(sum2)
    );

    bpo_rem_pipe #(.DW(DPW), .VW(NW), .QB(1), .SW(1)) u_phase_b (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v1_b),
        .i_dvd({pb1, F'(0)}), .i_dvs(spb_b1), .i_sb(sb_a1[0]),
        .o_valid(), .o_rem(rem_b2), .o_quo(), .o_dvs(spb_b2), .o_sb(inv2)
    );

    always_comb begin
        n_diff4 = {r_ph_b3[bpo_pkg::PH_W-1], r_ph_b3} - {r_ph_a3[bpo_pkg::PH_W-1], r_ph_a3};
        if (n_diff4 > bpo_pkg::OFF_LIMIT) begin
            n_off4 = OW'(bpo_pkg::OFF_LIMIT);
        end else if (n_diff4 < -bpo_pkg::OFF_LIMIT) begin
            n_off4 = OW'(-bpo_pkg::OFF_LIMIT);
        end else begin
            n_off4 = OW'(n_diff4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v3 <= v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ph_a3 <= deck_phase(rem_a2, spb_a2);
            r_ph_b3 <= deck_phase(rem_b2, spb_b2);
            r_sum3  <= sum2;
            r_inv3  <= inv2;
            r_off4  <= n_off4;
            r_mag4  <= n_off4[OW-1] ? bpo_pkg::MAG_W'(-n_off4) : bpo_pkg::MAG_W'(n_off4);
            r_sum4  <= r_sum3;
            r_inv4  <= r_inv3;
            r_prod5 <= bpo_pkg::PROD_W'(r_mag4 * r_sum4);
            r_off5  <= r_off4;
            r_inv5  <= r_inv4;
        end
    end

    // (mag * sum * 2^15) mod den, low quotient bits give the beat fraction
    bpo_rem_pipe #(.DW(FDW), .VW(bpo_pkg::DEN_W), .QB(bpo_pkg::Q_FRAC), .SW(OW + 1))
    u_beats (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_v5),
        .i_dvd({r_prod5, bpo_pkg::Q_FRAC'(0)}), .i_dvs(r_den), .i_sb({r_off5, r_inv5}),
        .o_valid(v6), .o_rem(rem6), .o_quo(quo6), .o_dvs(den6), .o_sb(sb6)
    );

    always_comb begin
        // round half up on the remainder; den is even
        n_q = bpo_pkg::BEATS_W'({1'b0, quo6})
            + bpo_pkg::BEATS_W'({rem6, 1'b0} >= {1'b0, den6});
        n_b = sb6[OW] ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
        if (n_b > bpo_pkg::HALF_BEAT) begin
            n_wrap = n_b - bpo_pkg::FULL_BEAT;
        end else if (n_b < -bpo_pkg::HALF_BEAT) begin
            n_wrap = n_b + bpo_pkg::FULL_BEAT;
        end else begin
            n_wrap = n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_inv   <= sb6[0];
            r_out_off   <= sb6[0] ? '0 : $signed(sb6[OW:1]);
            r_out_beats <= sb6[0] ? '0 : bpo_pkg::BEATS_W'(n_wrap);
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.offset_samples   = r_out_off;
    assign o_out.offset_beats_q15 = r_out_beats;
    assign o_out.tempo_invalid    = r_out_inv;

endmodule

// ----- hdl/beat_phase_offset_top.sv -----
// Path from acceptance to result valid: the bit-per-stage divider pipelines for
// beat length, deck phase and beat fraction, with registered stages between them.
// Throughput: one transaction per cycle; a held result stalls the pipeline and
// a two-entry input queue keeps taking transactions meanwhile.
// Reset: synchronous, clears pipeline valids and queue, sample rate to 44100.
// ----------------------------------------------------------------------------
// beat_phase_offset_top
// Phase offset between two decks, in frames and in beats at the mean tempo.
// ----------------------------------------------------------------------------
module beat_phase_offset_top #(
    parameter int POSITION_BITS      = 32,
    parameter int BEAT_FRACTION_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wen,
    input  logic [bpo_pkg::RATE_W-1:0] i_cfg_wdata,
    bpo_in_if.sink                     i_in,
    bpo_out_if.source                  o_out
);

    bpo_pkg::t_item             item;
    logic                       item_valid;
    logic                       item_ready;
    logic [bpo_pkg::RATE_W-1:0] sample_rate;

    bpo_front u_front (
        .i_clk, .i_rst_n, .i_cfg_wen, .i_cfg_wdata, .i_in,
        .o_item(item), .o_item_valid(item_valid), .i_item_ready(item_ready),
        .o_sample_rate(sample_rate)
    );

    bpo_back #(
        .POSITION_BITS(POSITION_BITS),
        .BEAT_FRACTION_BITS(BEAT_FRACTION_BITS)
    ) u_back (
        .i_clk, .i_rst_n, .i_sample_rate(sample_rate),
        .i_item(item), .i_item_valid(item_valid), .o_item_ready(item_ready),
        .o_out
    );

endmodule

// ----- tb/sv/beat_phase_offset_top_test.sv -----
// ----------------------------------------------------------------------------
// beat_phase_offset_top_test
// Self-checking bench for the beat phase offset block: a directed set and
// random deck pairs over several sample rates, with random source idling and
// sink stalls, checked against a cycle-free predictor of the offset math.
// ----------------------------------------------------------------------------
module beat_phase_offset_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = 16;
    localparam int LATENCY    = 163;
    localparam int DRAIN_WAIT = 2 * LATENCY;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 800;

    typedef struct {
        logic [31:0] pos_a;
        logic [31:0] pos_b;
        logic [15:0] tempo_a;
        logic [15:0] tempo_b;
    } t_deck_pair;

    typedef struct {
        logic signed [32:0] offset_samples;
        logic signed [15:0] offset_beats;
        logic               tempo_invalid;
    } t_offset;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wen;
    logic [bpo_pkg::RATE_W-1:0] i_cfg_wdata;

    bpo_in_if  in_ch ();
    bpo_out_if out_ch ();

    beat_phase_offset_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    t_deck_pair    pending_pairs[$];
    t_offset       expected_offsets[$];
    logic [bpo_pkg::RATE_W-1:0] rate_copy;
    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;
    bit            hold_request;
    int unsigned   hold_count;
    bit            in_took;
    int unsigned   errors;
    int unsigned   quiet_cycles;
    int unsigned   pairs_sent;
    int unsigned   offsets_checked;
    int unsigned   invalid_seen;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint deck_phase(logic [63:0] pos, logic [63:0] spb);
        logic [63:0] r;
        r = pos % spb;
        for (int k = 0; k < FRAC; k++) begin
            r = r << 1;
            if (r >= spb)
                r = r - spb;
        end
        if (2 * r >= spb)
            return -longint'((spb - r) >> FRAC);
        return longint'((r + ((64'd1 << FRAC) - 1)) >> FRAC);
    endfunction

    function automatic t_offset predict_offset(t_deck_pair p,
                                               logic [bpo_pkg::RATE_W-1:0] rate);
        t_offset     res;
        logic [63:0] spb_a, spb_b, mag, den, m, q;
        longint      off, beats;
        res.offset_samples = '0;
        res.offset_beats   = '0;
        res.tempo_invalid  = 1'b1;
        if (p.tempo_a == 0 || p.tempo_b == 0 || rate == 0)
            return res;
        spb_a = ((64'd6000 * rate) << FRAC) / p.tempo_a;
        spb_b = ((64'd6000 * rate) << FRAC) / p.tempo_b;
        off = deck_phase(p.pos_b, spb_b) - deck_phase(p.pos_a, spb_a);
        if (off > 64'sd4294967295)
            off = 64'sd4294967295;
        if (off < -64'sd4294967295)
            off = -64'sd4294967295;
        mag = off < 0 ? -off : off;
        den = 64'd12000 * rate;
        m = (mag * (p.tempo_a + p.tempo_b)) % den;
        q = ((m << 15) + den / 2) / den;
        beats = off < 0 ? -longint'(q) : longint'(q);
        if (beats > 16384)
            beats -= 32768;
        if (beats < -16384)
            beats += 32768;
        res.offset_samples = off[32:0];
        res.offset_beats   = beats[15:0];
        res.tempo_invalid  = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string field, longint want, longint got);
        $display("MISMATCH %s: expected %0d got %0d (result %0d)", field, want, got,
                 offsets_checked);
        errors++;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(in_ch.valid && !in_took)) begin
            if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_deck_pair p;
                p = pending_pairs.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.position_a    <= p.pos_a;
                in_ch.position_b    <= p.pos_b;
                in_ch.tempo_a_centi <= p.tempo_a;
                in_ch.tempo_b_centi <= p.tempo_b;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // sink readiness, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request && hold_count == 0) begin
            hold_count = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_count > 0) begin
            hold_count--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        in_took = 1'b0;
        if (i_rst_n) begin
            quiet_cycles++;
            if (in_ch.valid && in_ch.ready) begin
                t_deck_pair p;
                p.pos_a   = in_ch.position_a;
                p.pos_b   = in_ch.position_b;
                p.tempo_a = in_ch.tempo_a_centi;
                p.tempo_b = in_ch.tempo_b_centi;
                expected_offsets.push_back(predict_offset(p, rate_copy));
                in_took = 1'b1;
                pairs_sent++;
                quiet_cycles = 0;
            end
            if (out_ch.valid && out_ch.ready) begin
                quiet_cycles = 0;
                if (expected_offsets.size() == 0) begin
                    report_mismatch("unexpected result offset_samples", 0,
                                    out_ch.offset_samples);
                end else begin
                    t_offset e;
                    e = expected_offsets.pop_front();
                    if (out_ch.offset_samples !== e.offset_samples)
                        report_mismatch("offset_samples", e.offset_samples,
                                        out_ch.offset_samples);
                    if (out_ch.offset_beats_q15 !== e.offset_beats)
                        report_mismatch("offset_beats_q15", e.offset_beats,
                                        out_ch.offset_beats_q15);
                    if (out_ch.tempo_invalid !== e.tempo_invalid)
                        report_mismatch("tempo_invalid", e.tempo_invalid,
                                        out_ch.tempo_invalid);
                    if (e.tempo_invalid)
                        invalid_seen++;
                end
                offsets_checked++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TIMEOUT: no transaction for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic t_deck_pair make_pair(logic [31:0] pa, logic [31:0] pb,
                                             logic [15:0] ta, logic [15:0] tb);
        t_deck_pair p;
        p.pos_a = pa;
        p.pos_b = pb;
        p.tempo_a = ta;
        p.tempo_b = tb;
        return p;
    endfunction

    function automatic logic [15:0] random_tempo();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 4)
            return 16'd0;
        if (sel < 16)
            return 16'($urandom);
        return 16'($urandom_range(20000, 6000));
    endfunction

    function automatic t_deck_pair random_pair();
        t_deck_pair p;
        p.pos_a = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom;
        p.pos_b = ($urandom_range(9) == 0) ? ~32'($urandom_range(255)) : $urandom;
        p.tempo_a = random_tempo();
        // often match tempos, as decks in sync would
        p.tempo_b = ($urandom_range(3) == 0) ? p.tempo_a : random_tempo();
        return p;
    endfunction

    task automatic wait_idle();
        wait (pending_pairs.size() == 0 && expected_offsets.size() == 0 && !in_ch.valid);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_rate(logic [bpo_pkg::RATE_W-1:0] rate);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= rate;
        rate_copy = rate;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    initial begin
        logic [bpo_pkg::RATE_W-1:0] rates[9];
        in_ch.valid         = 1'b0;
        in_ch.position_a    = '0;
        in_ch.position_b    = '0;
        in_ch.tempo_a_centi = '0;
        in_ch.tempo_b_centi = '0;
        out_ch.ready        = 1'b0;
        i_cfg_wen           = 1'b0;
        i_cfg_wdata         = '0;
        i_rst_n             = 1'b0;
        rate_copy           = bpo_pkg::RATE_RESET;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_request        = 1'b0;
        hold_count          = 0;
        in_took             = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        pairs_sent = 0;
        offsets_checked = 0;
        invalid_seen = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed set at the reset rate: 120 BPM gives 22050 frames per beat
        pending_pairs.push_back(make_pair(0, 0, 12000, 12000));
        pending_pairs.push_back(make_pair(11025, 0, 12000, 12000));     // half beat
        pending_pairs.push_back(make_pair(0, 11025, 12000, 12000));
        pending_pairs.push_back(make_pair(11024, 11026, 12000, 12000));
        pending_pairs.push_back(make_pair(22049, 22051, 12000, 12000));
        pending_pairs.push_back(make_pair(32'hFFFF_FFFF, 0, 12000, 12000));
        pending_pairs.push_back(make_pair(0, 32'hFFFF_FFFF, 12000, 12000));
        pending_pairs.push_back(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        pending_pairs.push_back(make_pair(32'hFFFF_FFFF, 12345, 1, 1));
        pending_pairs.push_back(make_pair(5000000, 77, 1, 16'hFFFF));
        pending_pairs.push_back(make_pair(100, 200, 0, 12000));          // zero tempo A
        pending_pairs.push_back(make_pair(100, 200, 12000, 0));          // zero tempo B
        pending_pairs.push_back(make_pair(100, 200, 0, 0));
        pending_pairs.push_back(make_pair(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555));
        pending_pairs.push_back(make_pair(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA));
        pending_pairs.push_back(make_pair(16537, 5512, 12000, 12000));
        pending_pairs.push_back(make_pair(300000, 310000, 12800, 12750));
        pending_pairs.push_back(make_pair(1, 2, 17400, 8700));
        wait_idle();

        rates = '{18'd44100, 18'd8000, 18'd192000, 18'h3FFFF, 18'd1,
                  18'd0, 18'd48000, 18'd96000, 18'd44100};
        for (int ph = 0; ph < 9; ph++) begin
            write_rate(ph == 8 ? 18'($urandom_range(192000, 8000)) : rates[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int n = 0; n < 100; n++)
                pending_pairs.push_back(random_pair());
            // stop the sink while the source keeps offering, filling the pipe
            if (ph == 4)
                hold_request = 1'b1;
            wait_idle();
        end

        $display("Covered %0d deck pairs over 10 sample rate settings, %0d with a zero",
                 pairs_sent, invalid_seen);
        $display("tempo or rate; %0d results checked, %0d mismatches.", offsets_checked,
                 errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
